[rtl/sef_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_pkg: shared definitions for the stereo exponential fade
// Default widths, reset values, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package sef_pkg;

  localparam int SAMPLE_BITS_DEF        = 16;
  localparam int GAIN_FRACTION_BITS_DEF = 23;
  localparam int LENGTH_BITS_DEF        = 24;

  // decay factor is unsigned Q0.24 at any configuration
  localparam int DECAY_BITS = 24;

  localparam int unsigned RAMP_LENGTH_RESET  = 4800;
  localparam logic [DECAY_BITS-1:0] DECAY_RESET = 24'd16752749;

  // configuration register indexes
  localparam logic [1:0] REG_RAMP_LENGTH    = 2'd0;
  localparam logic [1:0] REG_DECAY_FACTOR   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN_ENABLE = 2'd2;
  localparam logic [1:0] REG_END_ENABLE     = 2'd3;

  // envelope status seen by the lanes and the merge stage
  typedef struct packed {
    logic in_ramp;
    logic active;
    logic effect_end;
  } sef_env_t;

  // per-word flags carried into the output register
  typedef struct packed {
    logic in_ramp;
    logic effect_end;
    logic buffer_done;
  } sef_flags_t;

endpackage

[rtl/sef_env.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_env: gain and frame step envelope
// Holds the Q1.23 gain and the saturating frame step; decays the gain once
// per word while the step is below the ramp length.
// ----------------------------------------------------------------------------
module sef_env #(
  parameter int GAIN_FRACTION_BITS = sef_pkg::GAIN_FRACTION_BITS_DEF,
  parameter int LENGTH_BITS        = sef_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            restart_i,
  input  logic                            advance_i,
  input  logic [LENGTH_BITS-1:0]          ramp_length_i,
  input  logic [sef_pkg::DECAY_BITS-1:0]  decay_factor_i,
  input  logic                            sustain_enable_i,
  input  logic                            end_enable_i,
  output logic [GAIN_FRACTION_BITS:0]     gain_o,
  output sef_pkg::sef_env_t               status_o
);
  import sef_pkg::*;

  localparam int GainBits = GAIN_FRACTION_BITS + 1;
  localparam int StepBits = LENGTH_BITS + 1;
  localparam logic [GainBits-1:0] GainOne = GainBits'(1) << GAIN_FRACTION_BITS;

  logic [GainBits-1:0]            gain_q, gain_d;
  logic [StepBits-1:0]            step_q, step_d;
  logic                           ramp_q, ramp_d;
  logic                           active_q, active_d;
  logic [GainBits+DECAY_BITS-1:0] product;
  logic                           ramp_now;
  logic [StepBits:0]              step_plus;

  assign product  = gain_q * decay_factor_i;
  assign ramp_now = step_q < {1'b0, ramp_length_i};
  assign step_plus = {1'b0, step_q} + (StepBits+1)'(1);

  always_comb begin
    gain_d   = gain_q;
    step_d   = step_q;
    ramp_d   = ramp_q;
    active_d = active_q;
    if (load_i && restart_i) begin
      gain_d = GainOne;
      step_d = '0;
    end else if (advance_i) begin
      ramp_d   = ramp_now;
      active_d = ramp_now || sustain_enable_i;
      if (ramp_now) begin
        gain_d = product[GainBits+DECAY_BITS-1:DECAY_BITS];
      end
      // saturate the step instead of wrapping
      if ((ramp_now || sustain_enable_i) && (step_q != '1)) begin
        step_d = step_plus[StepBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GainOne;
      step_q   <= '0;
      ramp_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      gain_q   <= gain_d;
      step_q   <= step_d;
      ramp_q   <= ramp_d;
      active_q <= active_d;
    end
  end

  assign gain_o              = gain_q;
  assign status_o.in_ramp    = ramp_q;
  assign status_o.active     = active_q;
  assign status_o.effect_end = end_enable_i && (step_plus >= (StepBits+1)'(ramp_length_i));

endmodule

[rtl/sef_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_lane: one channel scaler
// Captures a sample, scales its magnitude by the gain and restores the sign,
// which truncates toward zero, and passes the sample through while inactive.
// ----------------------------------------------------------------------------
module sef_lane #(
  parameter int SAMPLE_BITS        = sef_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = sef_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          scale_i,
  input  logic [GAIN_FRACTION_BITS:0]   gain_i,
  input  logic                          active_i,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int GainBits = GAIN_FRACTION_BITS + 1;

  logic signed [SAMPLE_BITS-1:0]   sample_q;
  logic [SAMPLE_BITS-1:0]          mag_q, mag_d;
  logic [SAMPLE_BITS-1:0]          magnitude;
  logic [SAMPLE_BITS+GainBits-1:0] product;
  logic                            neg;

  assign neg       = sample_q[SAMPLE_BITS-1];
  // most negative sample maps to its unsigned magnitude
  assign magnitude = neg ? (~sample_q + SAMPLE_BITS'(1)) : sample_q;
  assign product   = magnitude * gain_i;
  assign mag_d     = product[GAIN_FRACTION_BITS+SAMPLE_BITS-1:GAIN_FRACTION_BITS];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_i;
    end
    if (scale_i) begin
      mag_q <= mag_d;
    end
  end

  always_comb begin
    if (!active_i) begin
      result_o = sample_q;
    end else if (neg) begin
      result_o = ~mag_q + SAMPLE_BITS'(1);
    end else begin
      result_o = mag_q;
    end
  end

endmodule

[rtl/sef_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_merge: output register
// Joins both lanes and the frame flags into one word and holds it until
// the consumer takes it.
// ----------------------------------------------------------------------------
module sef_merge #(
  parameter int SAMPLE_BITS = sef_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  input  sef_pkg::sef_flags_t           flags_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          in_ramp_o,
  output logic                          effect_end_o,
  output logic                          buffer_done_o
);
  import sef_pkg::*;

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  sef_flags_t                    flags_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= left_i;
      right_q <= right_i;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign left_out_o    = left_q;
  assign right_out_o   = right_q;
  assign in_ramp_o     = flags_q.in_ramp;
  assign effect_end_o  = flags_q.effect_end;
  assign buffer_done_o = flags_q.buffer_done;

endmodule

[rtl/stereo_exponential_fade.sv]
`timescale 1ns / 1ps
// An accepted word passes the gain update, the lane multiply and the output
//   register in that order before out_valid_o rises.
// A new word is taken only once the last one has reached the output register,
//   which waits while a held output word is not taken; the shared gain
//   update must finish before both lane multipliers may use it.
// Reset: gain 1.0, frame step 0, registers at their defaults, no word held.
// ----------------------------------------------------------------------------
// stereo_exponential_fade: exponential fade-out envelope for stereo frames
// Decays a Q1.23 gain per frame and applies it to both channels in two lanes.
// ----------------------------------------------------------------------------
module stereo_exponential_fade #(
  parameter int SAMPLE_BITS        = sef_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = sef_pkg::GAIN_FRACTION_BITS_DEF,
  parameter int LENGTH_BITS        = sef_pkg::LENGTH_BITS_DEF,
  localparam int CFG_BITS = (LENGTH_BITS > sef_pkg::DECAY_BITS) ?
                            LENGTH_BITS : sef_pkg::DECAY_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          last_in_buffer_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          in_ramp_o,
  output logic                          effect_end_o,
  output logic                          buffer_done_o
);
  import sef_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GAIN  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [GAIN_FRACTION_BITS:0] GainOne =
    (GAIN_FRACTION_BITS+1)'(1) << GAIN_FRACTION_BITS;

  logic [1:0]                    state_q, state_d;
  logic [LENGTH_BITS-1:0]        ramp_length_q;
  logic [DECAY_BITS-1:0]         decay_factor_q;
  logic                          sustain_enable_q;
  logic                          end_enable_q;
  logic                          last_q;
  logic                          accept;
  logic                          merge_free;
  logic                          merge_load;
  logic [GAIN_FRACTION_BITS:0]   gain;
  sef_env_t                      env_status;
  sef_flags_t                    flags;
  logic signed [SAMPLE_BITS-1:0] left_lane, right_lane;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign merge_load = (state_q == ST_DONE) && merge_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE:  if (merge_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      ramp_length_q    <= LENGTH_BITS'(RAMP_LENGTH_RESET);
      decay_factor_q   <= DECAY_RESET;
      sustain_enable_q <= 1'b1;
      end_enable_q     <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RAMP_LENGTH:    ramp_length_q    <= cfg_data_i[LENGTH_BITS-1:0];
          REG_DECAY_FACTOR:   decay_factor_q   <= cfg_data_i[DECAY_BITS-1:0];
          REG_SUSTAIN_ENABLE: sustain_enable_q <= cfg_data_i[0];
          REG_END_ENABLE:     end_enable_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_in_buffer_i;
    end
  end

  sef_env #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .LENGTH_BITS        (LENGTH_BITS)
  ) u_env (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .restart_i        (restart_i),
    .advance_i        (state_q == ST_GAIN),
    .ramp_length_i    (ramp_length_q),
    .decay_factor_i   (decay_factor_q),
    .sustain_enable_i (sustain_enable_q),
    .end_enable_i     (end_enable_q),
    .gain_o           (gain),
    .status_o         (env_status)
  );

  sef_lane #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .load_i   (accept),
    .sample_i (left_in_i),
    .scale_i  (state_q == ST_SCALE),
    .gain_i   (gain),
    .active_i (env_status.active),
    .result_o (left_lane)
  );

  sef_lane #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .load_i   (accept),
    .sample_i (right_in_i),
    .scale_i  (state_q == ST_SCALE),
    .gain_i   (gain),
    .active_i (env_status.active),
    .result_o (right_lane)
  );

  assign flags.in_ramp     = env_status.in_ramp;
  assign flags.effect_end  = env_status.effect_end;
  assign flags.buffer_done = last_q;

  sef_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (merge_load),
    .left_i        (left_lane),
    .right_i       (right_lane),
    .flags_i       (flags),
    .free_o        (merge_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .in_ramp_o     (in_ramp_o),
    .effect_end_o  (effect_end_o),
    .buffer_done_o (buffer_done_o)
  );

`ifndef SYNTHESIS
  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_GAIN) && !in_ready_o)
    else $error("new word taken while previous word in flight");

  a_scale_then_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE) |=> (state_q == ST_DONE))
    else $error("lane results not handed to merge stage");

  a_gain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain <= GainOne)
    else $error("gain rose above one");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_load |=> out_valid_o)
    else $error("merged word lost");
`endif

endmodule
